FILE: src/ipcks_pkg.sv
// Shared types, constants and checksum helpers for the IPv4 checksum engine.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package ipcks_pkg;

  // L4 kind codes carried on the first byte of a packet
  localparam logic [1:0] KIND_ICMP = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  // Fixed header geometry and protocol numbers
  localparam int unsigned IP_HDR_LEN   = 20;
  localparam int unsigned IP_CSUM_LO   = 11;  // second byte of the IP checksum field
  localparam int unsigned PSEUDO_FIRST = 13;  // first address word ends here
  localparam logic [15:0] PROTO_TCP    = 16'd6;
  localparam logic [15:0] PROTO_UDP    = 16'd17;

  // Length field carried through the queue at its widest size
  localparam int unsigned MAX_LEN_W   = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  // One byte beat of a packet
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       last;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic        status;
  } out_beat_t;

  // Work item from the front to the back
  typedef struct packed {
    logic [15:0]          word;
    logic                 add_ip;
    logic                 add_l4;
    logic                 last;
    logic [MAX_LEN_W-1:0] total;
    logic [1:0]           kind;
    logic [7:0]           pad_byte;
  } op_t;

  // Offset of the L4 checksum field within the L4 part
  function automatic logic [5:0] field_offset(input logic [1:0] k);
    logic [5:0] off;
    unique case (k)
      KIND_TCP: off = 6'd16;
      KIND_UDP: off = 6'd6;
      default:  off = 6'd2;
    endcase
    return off;
  endfunction

  // Protocol number for the pseudo header, zero when none is used
  function automatic logic [15:0] proto_number(input logic [1:0] k);
    logic [15:0] p;
    unique case (k)
      KIND_TCP: p = PROTO_TCP;
      KIND_UDP: p = PROTO_UDP;
      default:  p = 16'd0;
    endcase
    return p;
  endfunction

  // One's-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage
`default_nettype wire

FILE: src/ipcks_front.sv
// Front end: takes packet bytes, pairs them into words and classifies each
// word for the IP and L4 sums. Uses ipcks_pkg.
`default_nettype none
module ipcks_front #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pkt_valid,
  input  wire ipcks_pkg::in_beat_t pkt_beat,
  input  wire logic               queue_full,
  output logic                    pkt_stall,
  output logic                    push,
  output ipcks_pkg::op_t          push_op
);

  localparam logic [LEN_WIDTH-1:0] MAX_COUNT = {LEN_WIDTH{1'b1}};

  logic [LEN_WIDTH-1:0] byte_count;
  logic [LEN_WIDTH-1:0] byte_count_next;
  logic [7:0]           held_high_byte;
  logic [7:0]           held_high_byte_next;
  logic [1:0]           packet_kind;
  logic [1:0]           packet_kind_next;

  logic                 first;
  logic [1:0]           kind_eff;
  logic                 take;
  logic                 odd;
  logic                 pseudo;
  logic [LEN_WIDTH-1:0] field_end;
  logic [LEN_WIDTH-1:0] count_inc;

  assign pkt_stall = queue_full;
  assign push      = pkt_valid && !pkt_stall;

  // Classify the current byte
  assign first     = (byte_count == '0);
  assign kind_eff  = first ? pkt_beat.kind : packet_kind;
  assign take      = (byte_count != MAX_COUNT);
  assign odd       = byte_count[0];
  assign pseudo    = (ipcks_pkg::proto_number(kind_eff) != 16'd0);
  assign field_end = LEN_WIDTH'(ipcks_pkg::IP_HDR_LEN)
                   + LEN_WIDTH'(ipcks_pkg::field_offset(kind_eff)) + LEN_WIDTH'(1);
  assign count_inc = take ? byte_count + LEN_WIDTH'(1) : byte_count;

  // Build the work item
  always_comb begin
    push_op          = '0;
    push_op.word     = {held_high_byte, pkt_beat.data_byte};
    push_op.last     = pkt_beat.last;
    push_op.total    = ipcks_pkg::MAX_LEN_W'(count_inc);
    push_op.kind     = kind_eff;
    push_op.pad_byte = (take && !odd) ? pkt_beat.data_byte : held_high_byte;
    if (take && odd) begin
      if (byte_count < LEN_WIDTH'(ipcks_pkg::IP_HDR_LEN)) begin
        push_op.add_ip = (byte_count != LEN_WIDTH'(ipcks_pkg::IP_CSUM_LO));
        push_op.add_l4 = pseudo && (byte_count >= LEN_WIDTH'(ipcks_pkg::PSEUDO_FIRST));
      end else begin
        push_op.add_l4 = (byte_count != field_end);
      end
    end
  end

  // Packet state update
  always_comb begin
    byte_count_next     = byte_count;
    held_high_byte_next = held_high_byte;
    packet_kind_next    = packet_kind;
    if (push) begin
      if (pkt_beat.last) begin
        byte_count_next     = '0;
        held_high_byte_next = 8'd0;
        packet_kind_next    = ipcks_pkg::KIND_ICMP;
      end else begin
        byte_count_next  = count_inc;
        packet_kind_next = kind_eff;
        if (take && !odd) begin
          held_high_byte_next = pkt_beat.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      held_high_byte <= 8'd0;
      packet_kind    <= ipcks_pkg::KIND_ICMP;
    end else begin
      byte_count     <= byte_count_next;
      held_high_byte <= held_high_byte_next;
      packet_kind    <= packet_kind_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/ipcks_queue.sv
// Short queue of work items between front and back.
// Uses ipcks_pkg for the item type and depth.
`default_nettype none
module ipcks_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ipcks_pkg::op_t push_op,
  input  wire logic           pop,
  output logic                full,
  output logic                nonempty,
  output ipcks_pkg::op_t      head
);

  localparam int unsigned DEPTH = ipcks_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ipcks_pkg::op_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == CNT_W'(DEPTH));
  assign nonempty = (fill != '0);
  assign head     = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/ipcks_back.sv
// Back end: accumulates the one's-complement sums, then folds in padding and
// pseudo header and drives the result register. Uses ipcks_pkg.
`default_nettype none
module ipcks_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           nonempty,
  input  wire ipcks_pkg::op_t head,
  output logic                pop,
  input  wire logic           res_stall,
  output logic                res_valid,
  output ipcks_pkg::out_beat_t res_beat
);

  logic [15:0] ip_sum;
  logic [15:0] l4_sum;
  logic [15:0] ip_sum_next;
  logic [15:0] l4_sum_next;

  // Finish stage registers
  logic                           fin_valid;
  logic [15:0]                    fin_ip;
  logic [15:0]                    fin_l4;
  logic [ipcks_pkg::MAX_LEN_W-1:0] fin_total;
  logic [1:0]                     fin_kind;
  logic [7:0]                     fin_pad;

  logic        res_free;
  logic        fin_free;
  logic        fin_move;
  logic [15:0] minlen;
  logic        short_pkt;
  logic [15:0] pad_word;
  logic [15:0] proto;
  logic [15:0] l4_len;
  logic [18:0] wide_sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  ipcks_pkg::out_beat_t res_next;

  assign res_free = !res_valid || !res_stall;
  assign fin_free = !fin_valid || res_free;
  assign fin_move = fin_valid && res_free;
  assign pop      = nonempty && (!head.last || fin_free);

  // Accumulate one word
  assign ip_sum_next = head.add_ip ? ipcks_pkg::oc_add(ip_sum, head.word) : ip_sum;
  assign l4_sum_next = head.add_l4 ? ipcks_pkg::oc_add(l4_sum, head.word) : l4_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      ip_sum <= 16'd0;
      l4_sum <= 16'd0;
    end else if (pop) begin
      ip_sum <= head.last ? 16'd0 : ip_sum_next;
      l4_sum <= head.last ? 16'd0 : l4_sum_next;
    end
  end

  // Hand the packet's sums to the finish stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (pop && head.last) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      fin_ip    <= ip_sum_next;
      fin_l4    <= l4_sum_next;
      fin_total <= head.total;
      fin_kind  <= head.kind;
      fin_pad   <= head.pad_byte;
    end
  end

  // Padding, pseudo header, fold and invert
  assign minlen    = 16'(ipcks_pkg::IP_HDR_LEN) + 16'(ipcks_pkg::field_offset(fin_kind))
                   + 16'd2;
  assign short_pkt = (16'(fin_total) < minlen);
  assign pad_word  = fin_total[0] ? {fin_pad, 8'd0} : 16'd0;
  assign proto     = ipcks_pkg::proto_number(fin_kind);
  assign l4_len    = (proto != 16'd0) ? 16'(fin_total) - 16'(ipcks_pkg::IP_HDR_LEN) : 16'd0;
  assign wide_sum  = 19'(fin_l4) + 19'(pad_word) + 19'(proto) + 19'(l4_len);
  assign fold1     = {1'b0, wide_sum[15:0]} + {14'd0, wide_sum[18:16]};
  assign fold2     = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    res_next = '0;
    res_next.status = short_pkt;
    if (!short_pkt) begin
      res_next.ip_checksum = ~fin_ip;
      res_next.l4_checksum = ~fold2;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      res_beat <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/ipv4_packet_checksum_engine.sv
// IPv4 checksum engine top level: front classifier, work queue, back accumulator.
// Uses ipcks_pkg, ipcks_front, ipcks_queue and ipcks_back.
//
// Takes one packet byte per cycle and sustains that rate across packet
// boundaries; a byte is held off only when the four-entry work queue is full,
// which happens when the result side stalls. After its last byte is taken, a
// packet's result passes the queue, the finish stage and the result register.
// Byte counts saturate at 2^LEN_WIDTH-1; later bytes are ignored.
`default_nettype none
module ipv4_packet_checksum_engine #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pkt_valid,
  output logic                      pkt_stall,
  input  wire ipcks_pkg::in_beat_t  pkt_beat,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output ipcks_pkg::out_beat_t      res_beat
);

  logic           push;
  ipcks_pkg::op_t push_op;
  logic           queue_full;
  logic           queue_nonempty;
  logic           pop;
  ipcks_pkg::op_t head;

  ipcks_front #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pkt_valid  (pkt_valid),
    .pkt_beat   (pkt_beat),
    .queue_full (queue_full),
    .pkt_stall  (pkt_stall),
    .push       (push),
    .push_op    (push_op)
  );

  ipcks_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .pop      (pop),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .head     (head)
  );

  ipcks_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (queue_nonempty),
    .head      (head),
    .pop       (pop),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_beat  (res_beat)
  );

endmodule
`default_nettype wire

FILE: dv/ipv4_packet_checksum_engine_test.sv
// Self-checking testbench for the IPv4 checksum engine: directed packets, then random traffic.
// Uses ipcks_pkg and ipv4_packet_checksum_engine; checks against its predictor or table rows.
`default_nettype none
module ipv4_packet_checksum_engine_test;

  localparam int unsigned LEN_W        = 16;
  localparam int unsigned COUNT_CAP    = (1 << LEN_W) - 1;
  localparam int unsigned RANDOM_BYTES = 1350;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // Kind three has no name in the package; status codes likewise
  localparam logic [1:0] KIND_RSVD    = 2'd3;
  localparam logic       STATUS_OK    = 1'b0;
  localparam logic       STATUS_SHORT = 1'b1;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_RAND} fill_t;

  // One directed packet; res is used only when typed is set
  typedef struct packed {
    logic [15:0]          len;
    logic [1:0]           kind;
    fill_t                fill;
    logic [15:0]          patch_at;
    logic [15:0]          patch_word;
    logic                 typed;
    ipcks_pkg::out_beat_t res;
  } pkt_row_t;

  localparam int N_ROWS = 15;
  localparam pkt_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{16'd1,  ipcks_pkg::KIND_ICMP, FILL_ZERO,  16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_SHORT}},
    '{16'd23, ipcks_pkg::KIND_ICMP, FILL_ONES,  16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_SHORT}},
    '{16'd24, ipcks_pkg::KIND_ICMP, FILL_ZERO,  16'd0,  16'h0000,
      1'b1, '{16'hFFFF, 16'hFFFF, STATUS_OK}},
    '{16'd24, ipcks_pkg::KIND_ICMP, FILL_ONES,  16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_OK}},
    '{16'd24, KIND_RSVD,            FILL_ONES,  16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_OK}},
    '{16'd37, ipcks_pkg::KIND_TCP,  FILL_ONES,  16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_SHORT}},
    '{16'd38, ipcks_pkg::KIND_TCP,  FILL_ZERO,  16'd0,  16'h0000,
      1'b1, '{16'hFFFF, 16'hFFE7, STATUS_OK}},
    '{16'd27, ipcks_pkg::KIND_UDP,  FILL_ZERO,  16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_SHORT}},
    '{16'd28, ipcks_pkg::KIND_UDP,  FILL_ZERO,  16'd0,  16'h0000,
      1'b1, '{16'hFFFF, 16'hFFE6, STATUS_OK}},
    // payload word chosen so the UDP sum comes out as zero, given as zero
    '{16'd30, ipcks_pkg::KIND_UDP,  FILL_ZERO,  16'd28, 16'hFFE4,
      1'b1, '{16'hFFFF, 16'h0000, STATUS_OK}},
    '{16'd20, ipcks_pkg::KIND_TCP,  FILL_COUNT, 16'd0,  16'h0000,
      1'b1, '{16'h0000, 16'h0000, STATUS_SHORT}},
    '{16'd25, ipcks_pkg::KIND_ICMP, FILL_ONES,  16'd0,  16'h0000, 1'b0, '0},
    '{16'd61, ipcks_pkg::KIND_TCP,  FILL_COUNT, 16'd0,  16'h0000, 1'b0, '0},
    '{16'd47, ipcks_pkg::KIND_UDP,  FILL_RAND,  16'd0,  16'h0000, 1'b0, '0},
    '{16'd99, KIND_RSVD,            FILL_COUNT, 16'd0,  16'h0000, 1'b0, '0}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 pkt_valid = 1'b0;
  ipcks_pkg::in_beat_t  pkt_beat  = '0;
  logic                 res_stall = 1'b0;
  logic                 pkt_stall;
  logic                 res_valid;
  ipcks_pkg::out_beat_t res_beat;

  ipv4_packet_checksum_engine #(.LEN_WIDTH(LEN_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt_beat (pkt_beat),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_beat (res_beat)
  );

  always #5 clk = ~clk;

  // Idling controls, written by the stimulus process
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold_req  = 1'b0;

  ipcks_pkg::out_beat_t pending_sums[$];
  int unsigned bytes_sent   = 0;
  int unsigned packets_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;

  // Predictor state
  int unsigned seen_bytes = 0;
  logic [15:0] ip_acc     = '0;
  logic [15:0] l4_acc     = '0;
  logic [7:0]  hi_byte    = '0;
  logic [1:0]  pkt_kind   = '0;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    int unsigned s;
    s = int'(a) + int'(b);
    return 16'((s & 32'hFFFF) + (s >> 16));
  endfunction

  // Byte index of the second byte of the L4 checksum field
  function automatic int unsigned l4_field_end(input logic [1:0] k);
    case (k)
      ipcks_pkg::KIND_TCP: return ipcks_pkg::IP_HDR_LEN + 17;
      ipcks_pkg::KIND_UDP: return ipcks_pkg::IP_HDR_LEN + 7;
      default:             return ipcks_pkg::IP_HDR_LEN + 3;
    endcase
  endfunction

  function automatic logic [15:0] pseudo_proto(input logic [1:0] k);
    case (k)
      ipcks_pkg::KIND_TCP: return ipcks_pkg::PROTO_TCP;
      ipcks_pkg::KIND_UDP: return ipcks_pkg::PROTO_UDP;
      default:             return 16'd0;
    endcase
  endfunction

  // Advance the checksum state by one byte; returns 1 with the result on a last byte
  function automatic bit predict_checksums(input ipcks_pkg::in_beat_t b,
                                           output ipcks_pkg::out_beat_t r);
    int unsigned idx;
    logic [15:0] w;
    logic [15:0] l4;
    bit          pseudo;
    idx = seen_bytes;
    if (idx == 0) pkt_kind = b.kind;
    pseudo = pseudo_proto(pkt_kind) != 16'd0;
    if (idx < COUNT_CAP) begin
      if (idx % 2 == 0) begin
        hi_byte = b.data_byte;
      end else begin
        w = {hi_byte, b.data_byte};
        if (idx < ipcks_pkg::IP_HDR_LEN) begin
          if (idx != ipcks_pkg::IP_CSUM_LO) ip_acc = ones_add(ip_acc, w);
          if (pseudo && idx >= ipcks_pkg::PSEUDO_FIRST) l4_acc = ones_add(l4_acc, w);
        end else if (idx != l4_field_end(pkt_kind)) begin
          l4_acc = ones_add(l4_acc, w);
        end
      end
      seen_bytes = idx + 1;
    end
    r = '0;
    if (!b.last) return 1'b0;
    if (seen_bytes > l4_field_end(pkt_kind)) begin
      l4 = l4_acc;
      // odd length: trailing byte padded with a zero low byte
      if (seen_bytes % 2 == 1) l4 = ones_add(l4, {hi_byte, 8'h00});
      if (pseudo) begin
        l4 = ones_add(l4, pseudo_proto(pkt_kind));
        l4 = ones_add(l4, 16'(seen_bytes - ipcks_pkg::IP_HDR_LEN));
      end
      r.ip_checksum = ~ip_acc;
      r.l4_checksum = ~l4;
      r.status      = STATUS_OK;
    end else begin
      r.status = STATUS_SHORT;
    end
    seen_bytes = 0;
    ip_acc     = '0;
    l4_acc     = '0;
    hi_byte    = '0;
    pkt_kind   = '0;
    return 1'b1;
  endfunction

  // Offer one beat, idling at random first; returns once it is taken
  task automatic send_byte(input ipcks_pkg::in_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pkt_valid <= 1'b0;
      @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt_beat  <= b;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input int unsigned len, input logic [1:0] k, input fill_t fill,
                             input int unsigned patch_at, input logic [15:0] patch_word,
                             input bit typed, input ipcks_pkg::out_beat_t typed_res);
    ipcks_pkg::in_beat_t  b;
    ipcks_pkg::out_beat_t r;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO:  b.data_byte = 8'h00;
        FILL_ONES:  b.data_byte = 8'hFF;
        FILL_COUNT: b.data_byte = i[7:0];
        default:    b.data_byte = 8'($urandom);
      endcase
      if (patch_at != 0 && i == patch_at)     b.data_byte = patch_word[15:8];
      if (patch_at != 0 && i == patch_at + 1) b.data_byte = patch_word[7:0];
      // kind only counts on the first byte; scramble it elsewhere
      b.kind = (i == 0) ? k : 2'($urandom_range(0, 3));
      b.last = (i == len - 1);
      send_byte(b);
      if (predict_checksums(b, r)) pending_sums.push_back(typed ? typed_res : r);
    end
    packets_sent++;
  endtask

  // Mostly well-formed packets with random content, some cut short
  task automatic send_random_packet();
    logic [1:0]  k;
    int unsigned min_len;
    int unsigned len;
    k       = 2'($urandom_range(0, 3));
    min_len = l4_field_end(k) + 1;
    if ($urandom_range(0, 99) < 12) len = $urandom_range(1, min_len - 1);
    else len = $urandom_range(min_len, min_len + 48);
    send_packet(len, k, FILL_RAND, 0, 16'h0000, 1'b0, '0);
  endtask

  // Result side: random stall, plus one long hold-off on request
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    ipcks_pkg::out_beat_t want;
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        $error("result with no packet outstanding: ip %h l4 %h status %b",
               res_beat.ip_checksum, res_beat.l4_checksum, res_beat.status);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (res_beat.ip_checksum !== want.ip_checksum) begin
          $error("ip_checksum: expected %h, got %h", want.ip_checksum, res_beat.ip_checksum);
          errors++;
        end
        if (res_beat.l4_checksum !== want.l4_checksum) begin
          $error("l4_checksum: expected %h, got %h", want.l4_checksum, res_beat.l4_checksum);
          errors++;
        end
        if (res_beat.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, res_beat.status);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, pending_sums.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed packets under the first idling mix
    send_idle_pct  = 19;
    recv_stall_pct <= 51;
    for (int r = 0; r < N_ROWS; r++) begin
      send_packet(DIRECTED_ROWS[r].len, DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].fill,
                  DIRECTED_ROWS[r].patch_at, DIRECTED_ROWS[r].patch_word,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    end

    // Random traffic in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 19;
          recv_stall_pct <= 51;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct <= 19;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
          long_hold_req  <= 1'b1;  // result side backs up, input must stall
        end
      endcase
      target = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < target)
        send_random_packet();
    end

    pkt_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d packets, %0d bytes, all kinds, short and odd lengths.",
             packets_sent, bytes_sent);
    $display("Checked %0d results under mixed stalls and one long result hold-off; %0d errors.",
             results_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
